/* hw/rtl/argb_pixel_blend_macros.svh */
// ----------------------------------------------------------------------------
// argb_pixel_blend assertion macros
// Clocked assertions with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ARGB_PIXEL_BLEND_MACROS_SVH
`define ARGB_PIXEL_BLEND_MACROS_SVH

// assertion sampled on the rising edge, gated off while reset is active
`define APB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion sampled on the rising edge, no reset gating
`define APB_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/apb_pkg.sv */
// ----------------------------------------------------------------------------
// apb_pkg
// Types, codes and helpers shared by the pixel blend block.
// ----------------------------------------------------------------------------
package apb_pkg;

	localparam int unsigned FmtW   = 2;
	localparam int unsigned IdxW   = 2;
	localparam int unsigned ChanW  = 8;
	localparam int unsigned ProdW  = 2 * ChanW;
	localparam int unsigned NChan  = 4;
	localparam int unsigned PixW   = NChan * ChanW;

	localparam logic [FmtW-1:0] FMT_XRGB   = 2'd0;
	localparam logic [FmtW-1:0] FMT_ZRGB   = 2'd1;
	localparam logic [FmtW-1:0] FMT_ARGB   = 2'd2;
	localparam logic [FmtW-1:0] FMT_BARGB  = 2'd3;

	localparam logic [IdxW-1:0] REG_SOURCE_FORMAT = 2'd0;
	localparam logic [IdxW-1:0] REG_TARGET_FORMAT = 2'd1;

	localparam logic [PixW-1:0]  RGB_MASK   = 32'h00FF_FFFF;
	localparam logic [PixW-1:0]  ALPHA_ONE  = 32'hFF00_0000;
	localparam logic [PixW-1:0]  ALPHA_ZERO = 32'h0000_0000;
	localparam logic [ChanW-1:0] CHAN_MAX   = 8'd255;

	typedef struct packed {
		logic [PixW-1:0] source_pixel;
		logic [PixW-1:0] target_pixel;
	} in_item_t;

	typedef struct packed {
		logic [PixW-1:0] result_pixel;
		logic            changed;
	} out_item_t;

	typedef struct packed {
		logic blend;
		logic keep_alpha;
		logic changed;
	} blend_ctl_t;

	// floor(x / 255), exact for x <= 255 * 255
	function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
		logic [ProdW:0] xp;
		logic [ProdW:0] sum;
		begin
			xp  = {1'b0, x} + 17'd1;
			sum = xp + (xp >> ChanW);
			return sum[ProdW-1:ChanW];
		end
	endfunction

endpackage

/* hw/rtl/argb_pixel_blend.sv */
// ----------------------------------------------------------------------------
// argb_pixel_blend
// ARGB8888 source-over blend with copy, alpha-force and skip modes.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   in_data   (source_pixel, target_pixel)
//   out      out_valid/out_stall out_data  (result_pixel, changed)
//   cfg      cfg_we              cfg_index, cfg_data
//
// Four register stages: input, products, divide by 255, sum and pack.
// One item per cycle unless out_stall holds the stages back; an accepted
// item goes through the products, divide and pack stages before out_valid rises.
// Each stage advances when it is empty or the next stage advances, so
// bubbles close up under out_stall and a stall drops or repeats nothing.
// arst_n clears the valid bits and sets both format registers to 0.
// ----------------------------------------------------------------------------
module argb_pixel_blend import apb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [IdxW-1:0] cfg_index,
	input  logic [FmtW-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  in_item_t        in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output out_item_t       out_data
);

	logic [FmtW-1:0] src_fmt_q, tgt_fmt_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	in_item_t   item_s1;

	blend_ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic [PixW-1:0]  bypass_s2, bypass_s3;
	logic [ProdW-1:0] sprod_s2 [NChan];
	logic [ProdW-1:0] tprod_s2 [NChan];
	logic [ChanW-1:0] squot_s3 [NChan];
	logic [ChanW-1:0] tquot_s3 [NChan];
	logic [PixW-1:0]  pix_s4;

	blend_ctl_t      ctl_d;
	logic [PixW-1:0] bypass_d;
	logic [ChanW-1:0] alpha_d;
	logic [ChanW-1:0] inv_alpha_d;
	logic [PixW-1:0]  mix_d;

	assign en_s4 = !valid_s4 || !out_stall;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_XRGB;
			tgt_fmt_q <= FMT_XRGB;
		end else if (cfg_we) begin
			if (cfg_index == REG_SOURCE_FORMAT) begin
				src_fmt_q <= cfg_data;
			end else if (cfg_index == REG_TARGET_FORMAT) begin
				tgt_fmt_q <= cfg_data;
			end
		end
	end

	// mode decode and bypass pixel
	always_comb begin
		logic check;
		logic force_one;
		logic skip;
		check       = 1'b0;
		force_one   = 1'b0;
		skip        = 1'b0;
		ctl_d       = '{blend: 1'b0, keep_alpha: 1'b1, changed: 1'b1};
		alpha_d     = item_s1.source_pixel[PixW-1 -: ChanW];
		inv_alpha_d = CHAN_MAX - alpha_d;
		priority if (src_fmt_q == FMT_BARGB) begin
			check = 1'b1;
			ctl_d.keep_alpha = (tgt_fmt_q != FMT_ZRGB);
		end else if (src_fmt_q == FMT_ARGB) begin
			check = 1'b1;
			ctl_d.blend = 1'b1;
			ctl_d.keep_alpha = (tgt_fmt_q != FMT_ZRGB);
		end else if (tgt_fmt_q == FMT_ARGB || tgt_fmt_q == FMT_BARGB) begin
			ctl_d.keep_alpha = 1'b0;
			force_one = 1'b1;
		end else if (tgt_fmt_q == FMT_ZRGB && src_fmt_q == FMT_XRGB) begin
			ctl_d.keep_alpha = 1'b0;
		end else begin
			ctl_d.keep_alpha = 1'b1;
		end
		if (alpha_d == CHAN_MAX || !check) begin
			ctl_d.blend = 1'b0;
		end
		skip = check && (alpha_d == '0);
		if (skip) begin
			ctl_d.blend   = 1'b0;
			ctl_d.changed = 1'b0;
			bypass_d      = item_s1.target_pixel;
		end else if (ctl_d.keep_alpha) begin
			bypass_d = item_s1.source_pixel;
		end else begin
			bypass_d = (force_one ? ALPHA_ONE : ALPHA_ZERO) | (item_s1.source_pixel & RGB_MASK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			item_s1 <= in_data;
		end
		if (en_s2 && valid_s1) begin
			ctl_s2    <= ctl_d;
			bypass_s2 <= bypass_d;
			for (int i = 0; i < NChan - 1; i++) begin
				sprod_s2[i] <= ProdW'(item_s1.source_pixel[i*ChanW +: ChanW]) *
					ProdW'(alpha_d);
				tprod_s2[i] <= ProdW'(item_s1.target_pixel[i*ChanW +: ChanW]) *
					ProdW'(inv_alpha_d);
			end
			sprod_s2[NChan-1] <= ProdW'(alpha_d) * ProdW'(alpha_d);
			tprod_s2[NChan-1] <= ProdW'(item_s1.target_pixel[PixW-1 -: ChanW]) *
				ProdW'(inv_alpha_d);
		end
		if (en_s3 && valid_s2) begin
			ctl_s3    <= ctl_s2;
			bypass_s3 <= bypass_s2;
			for (int i = 0; i < NChan; i++) begin
				squot_s3[i] <= div255(sprod_s2[i]);
				tquot_s3[i] <= div255(tprod_s2[i]);
			end
		end
		if (en_s4 && valid_s3) begin
			ctl_s4 <= ctl_s3;
			pix_s4 <= ctl_s3.blend ? mix_d : bypass_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < NChan; i++) begin
			mix_d[i*ChanW +: ChanW] = squot_s3[i] + tquot_s3[i];
		end
		if (!ctl_s3.keep_alpha) begin
			mix_d[PixW-1 -: ChanW] = '0;
		end
	end

	assign out_valid             = valid_s4;
	assign out_data.result_pixel = pix_s4;
	assign out_data.changed      = ctl_s4.changed;

endmodule

/* hw/rtl/apb_checker.sv */
// ----------------------------------------------------------------------------
// apb_checker
// Port-level checks on the pixel blend block, bound to its top level.
// ----------------------------------------------------------------------------
`include "argb_pixel_blend_macros.svh"

module apb_checker import apb_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	logic [2:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b0, in_acc} - {2'b0, out_acc};
		end
	end

	`APB_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid,
		"out item dropped while stalled")
	`APB_ASSERT(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(out_data),
		"out item changed while stalled")
	`APB_ASSERT(a_no_phantom, clk, arst_n, out_valid |-> pending_q != 3'd0,
		"out item without a pending in item")
	`APB_ASSERT(a_no_idle_stall, clk, arst_n, !out_valid |-> !in_stall,
		"in stalled while out side is empty")

endmodule

bind argb_pixel_blend apb_checker u_apb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* bench/tb_argb_pixel_blend.sv */
// ----------------------------------------------------------------------------
// tb_argb_pixel_blend
// Self-checking bench for the ARGB8888 pixel blend block. Items are queued
// for a bursty driver. Each accepted item is predicted against a shadow
// copy of the format registers. A monitor behind a randomly stalling
// receiver compares every result field by field. All sixteen
// source/target format pairs are visited. A write to an unused register
// index is also exercised.
// ----------------------------------------------------------------------------
module tb_argb_pixel_blend;
	import apb_pkg::*;

	localparam logic [IdxW-1:0] REG_UNUSED = 2'd2;
	localparam int unsigned     HOLD_CYCLES = 80;
	localparam int unsigned     IDLE_LIMIT  = 2000;
	localparam int unsigned     DRAIN_CYCLES = 8;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_we = 1'b0;
	logic [IdxW-1:0] cfg_index = '0;
	logic [FmtW-1:0] cfg_data = '0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	in_item_t        in_data = '0;
	logic            out_valid;
	logic            out_stall = 1'b1;
	out_item_t       out_data;

	logic [FmtW-1:0] fmt_source = FMT_XRGB;
	logic [FmtW-1:0] fmt_target = FMT_XRGB;

	in_item_t    pixel_queue[$];
	out_item_t   expected_pixels[$];
	int unsigned fail_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned idle_cycles = 0;

	argb_pixel_blend dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	function automatic logic [ChanW-1:0] mix_channel(input logic [ChanW-1:0] s,
			input logic [ChanW-1:0] t, input logic [ChanW-1:0] a);
		int unsigned fg;
		int unsigned bg;
		fg = (32'(s) * 32'(a)) / 32'(CHAN_MAX);
		bg = (32'(t) * (32'(CHAN_MAX) - 32'(a))) / 32'(CHAN_MAX);
		return ChanW'(fg + bg);
	endfunction

	function automatic out_item_t predict_blend(input in_item_t px);
		logic [ChanW-1:0] alpha;
		logic [ChanW-1:0] alpha_forced;
		logic             composite;
		logic             binary;
		logic             alpha_kept;
		out_item_t        r;
		alpha = px.source_pixel[PixW-1 -: ChanW];
		alpha_forced = ALPHA_ZERO[PixW-1 -: ChanW];
		composite = 1'b0;
		binary = 1'b0;
		alpha_kept = 1'b1;
		if (fmt_source == FMT_BARGB) begin
			binary = 1'b1;
			alpha_kept = (fmt_target != FMT_ZRGB);
		end else if (fmt_source == FMT_ARGB) begin
			composite = 1'b1;
			alpha_kept = (fmt_target != FMT_ZRGB);
		end else if (fmt_target == FMT_ARGB || fmt_target == FMT_BARGB) begin
			alpha_kept = 1'b0;
			alpha_forced = ALPHA_ONE[PixW-1 -: ChanW];
		end else if (fmt_target == FMT_ZRGB && fmt_source == FMT_XRGB) begin
			alpha_kept = 1'b0;
		end
		r.changed = 1'b1;
		if ((binary || composite) && alpha == '0) begin
			r.result_pixel = px.target_pixel;
			r.changed = 1'b0;
		end else if (composite && alpha != CHAN_MAX) begin
			for (int c = 0; c < NChan - 1; c++)
				r.result_pixel[c*ChanW +: ChanW] = mix_channel(px.source_pixel[c*ChanW +: ChanW],
					px.target_pixel[c*ChanW +: ChanW], alpha);
			r.result_pixel[PixW-1 -: ChanW] = alpha_kept ?
				mix_channel(alpha, px.target_pixel[PixW-1 -: ChanW], alpha) : alpha_forced;
		end else begin
			r.result_pixel = alpha_kept ? px.source_pixel :
				{alpha_forced, px.source_pixel[PixW-ChanW-1:0]};
		end
		return r;
	endfunction

	function automatic logic [PixW-1:0] random_pixel();
		logic [PixW-1:0] px;
		px = $urandom();
		case ($urandom_range(0, 7))
			0: px[PixW-1 -: ChanW] = 8'h00;
			1: px[PixW-1 -: ChanW] = 8'hFF;
			2: px[PixW-1 -: ChanW] = 8'h01;
			3: px[PixW-1 -: ChanW] = 8'hFE;
			4: px = ($urandom_range(0, 1) != 0) ? (px | RGB_MASK) : (px & ~RGB_MASK);
			default: ;
		endcase
		return px;
	endfunction

	task automatic queue_item(input logic [PixW-1:0] src, input logic [PixW-1:0] tgt);
		in_item_t it;
		it.source_pixel = src;
		it.target_pixel = tgt;
		pixel_queue.push_back(it);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
	endtask

	task automatic write_format(input logic [IdxW-1:0] idx, input logic [FmtW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_SOURCE_FORMAT)
			fmt_source = val;
		else if (idx == REG_TARGET_FORMAT)
			fmt_target = val;
	endtask

	task automatic set_formats(input logic [FmtW-1:0] src, input logic [FmtW-1:0] tgt);
		wait_idle();
		write_format(REG_SOURCE_FORMAT, src);
		write_format(REG_TARGET_FORMAT, tgt);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// sender: bursts of items with random gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_pixels.push_back(predict_blend(in_data));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					in_data <= pixel_queue.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check results, then pick the next stall state
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected result: result_pixel %h changed %b",
						out_data.result_pixel, out_data.changed);
					fail_count++;
				end else begin
					out_item_t exp_item;
					exp_item = expected_pixels.pop_front();
					if (out_data.result_pixel !== exp_item.result_pixel) begin
						$error("result_pixel: expected %h, actual %h",
							exp_item.result_pixel, out_data.result_pixel);
						fail_count++;
					end
					if (out_data.changed !== exp_item.changed) begin
						$error("changed: expected %b, actual %b",
							exp_item.changed, out_data.changed);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						out_stall <= 1'b1;
						stall_left = $urandom_range(0, 6);
					end
					1: begin
						out_stall <= 1'b0;
						stall_left = $urandom_range(20, 50);
					end
					default: begin
						out_stall <= 1'b0;
						stall_left = $urandom_range(0, 4);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n_items;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_item(32'h0000_0000, 32'hFFFF_FFFF);
		queue_item(32'hFFFF_FFFF, 32'h0000_0000);
		queue_item(32'h5A3C_96E1, 32'hA5C3_691E);
		wait_idle();
		write_format(REG_UNUSED, FMT_BARGB);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		queue_item(32'h00AB_CDEF, 32'h1234_5678);
		queue_item(32'h80FF_00FF, 32'h7F00_FF00);

		set_formats(FMT_ARGB, FMT_ARGB);
		queue_item(32'h00FF_FFFF, 32'h1234_5678);
		queue_item(32'h01FF_FFFF, 32'h0000_0000);
		queue_item(32'h0100_0000, 32'hFFFF_FFFF);
		queue_item(32'hFEFF_FFFF, 32'h0000_0000);
		queue_item(32'hFE00_0000, 32'hFFFF_FFFF);
		queue_item(32'hFF12_3456, 32'h89AB_CDEF);
		queue_item(32'h80FF_FFFF, 32'hFFFF_FFFF);
		queue_item(32'h8000_0000, 32'h0000_0000);

		set_formats(FMT_BARGB, FMT_ZRGB);
		queue_item(32'h00FF_FFFF, 32'h1234_5678);
		queue_item(32'h01AB_CDEF, 32'h0000_0000);
		queue_item(32'hFF00_0000, 32'hFFFF_FFFF);

		set_formats(FMT_XRGB, FMT_BARGB);
		queue_item(32'h0012_3456, 32'h0000_0000);
		queue_item(32'h8000_0000, 32'hFFFF_FFFF);

		for (int s = 0; s < 4; s++) begin
			for (int t = 0; t < 4; t++) begin
				set_formats(FmtW'(s), FmtW'(t));
				n_items = (FmtW'(s) == FMT_ARGB) ? 80 : 34;
				for (int k = 0; k < n_items; k++)
					queue_item(random_pixel(), random_pixel());
				if (s * 4 + t == 5 || s * 4 + t == 10)
					hold_requests++;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (expected_pixels.size() != 0) begin
			$error("%0d results never arrived", expected_pixels.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/apb_pkg.sv
hw/rtl/argb_pixel_blend.sv
hw/rtl/apb_checker.sv
bench/tb_argb_pixel_blend.sv
